// ----- rtl/ordered_list_store_top_defines.svh -----
// Assertion macros shared by the ordered list store RTL.
// Included by the modules that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef ORDERED_LIST_STORE_TOP_DEFINES_SVH
`define ORDERED_LIST_STORE_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define OLST_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold whenever the antecedent holds.
`define OLST_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/olst_pkg.sv -----
// Package for the ordered list store: operation codes, status codes, states and result type.
// No dependencies; used by olst_seq, olst_outreg and the top level.
package olst_pkg;

    // Operation codes carried on the mode field.
    typedef enum logic [2:0] {
        MODE_READ   = 3'd0,
        MODE_FIND   = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_DELETE = 3'd3,
        MODE_CLEAR  = 3'd4
    } olst_mode_t;

    // Status codes reported with every result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_RDW,
        S_FIND,
        S_INS,
        S_DEL,
        S_RESP
    } olst_state_t;

    // One result item.
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data;
        logic [7:0] found_at;
        logic [7:0] count;
        logic       empty_res;
    } olst_result_t;

endpackage

// ----- rtl/olst_mem.sv -----
// Element memory of the ordered list store: one write port, one read port, registered read.
// Stand-alone; no package needed.
module olst_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/olst_seq.sv -----
// Sequencer of the ordered list store: checks each request, walks the element memory
// and forms the result. Uses olst_pkg and the assertion macros header.
`include "ordered_list_store_top_defines.svh"

module olst_seq #(
    parameter int CAPACITY = 128,
    parameter int AW       = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           mode,
    input  logic [7:0]           position,
    input  logic [7:0]           value,
    output logic                 res_valid,
    input  logic                 res_ready,
    output olst_pkg::olst_result_t res,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output logic [7:0]           mem_wdata,
    output logic [AW-1:0]        mem_raddr,
    input  logic [7:0]           mem_rdata
);
    import olst_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > 8) ? CW : 8) + 1;
    localparam logic [CMPW-1:0] CAP_EXT = CMPW'(CAPACITY);
    localparam logic [CMPW-1:0] ONE_EXT = CMPW'(1);

    olst_state_t   state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [7:0]    pos_reg, pos_next;
    logic [7:0]    val_reg, val_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          pend_vld_reg, pend_vld_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic [1:0]    status_reg, status_next;
    logic [7:0]    data_reg, data_next;
    logic [7:0]    found_reg, found_next;

    logic [CMPW-1:0] in_pos_ext, pos_ext, fill_ext, scan_ext, pend_ext;
    logic [CMPW-1:0] pos_m1_ext;

    assign in_pos_ext = CMPW'(position);
    assign pos_ext    = CMPW'(pos_reg);
    assign pos_m1_ext = pos_ext - ONE_EXT;
    assign fill_ext   = CMPW'(fill_reg);
    assign scan_ext   = CMPW'(scan_reg);
    assign pend_ext   = CMPW'(pend_idx_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        scan_reg     <= scan_next;
        pend_idx_reg <= pend_idx_next;
        status_reg   <= status_next;
        data_reg     <= data_next;
        found_reg    <= found_next;
    end

    // Next state, memory accesses and result fields.
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        scan_next     = scan_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        status_next   = status_reg;
        data_next     = data_reg;
        found_next    = found_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = val_reg;
        mem_raddr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    pos_next      = position;
                    val_next      = value;
                    pend_vld_next = 1'b0;
                    status_next   = ST_OK;
                    data_next     = '0;
                    found_next    = '0;
                    state_next    = S_RESP;
                    unique case (mode)
                        MODE_READ:
                        begin
                            if (in_pos_ext == '0 || in_pos_ext > fill_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        MODE_FIND:
                        begin
                            scan_next  = '0;
                            state_next = S_FIND;
                        end
                        MODE_INSERT:
                        begin
                            if (in_pos_ext == '0 || in_pos_ext > fill_ext + ONE_EXT)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (fill_ext == CAP_EXT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                scan_next  = fill_reg;
                                state_next = S_INS;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (in_pos_ext == '0 || in_pos_ext > fill_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                scan_next  = in_pos_ext[CW-1:0];
                                state_next = S_DEL;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                            // Unused codes change nothing.
                        end
                    endcase
                end
            end

            S_RD:
            begin
                mem_raddr  = pos_m1_ext[AW-1:0];
                state_next = S_RDW;
            end

            S_RDW:
            begin
                data_next  = mem_rdata;
                state_next = S_RESP;
            end

            // Linear search, one element read per cycle, each compared in the next cycle.
            S_FIND:
            begin
                if (pend_vld_reg && mem_rdata == val_reg)
                begin
                    found_next    = 8'((pend_ext + ONE_EXT) & CMPW'(8'hff));
                    pend_vld_next = 1'b0;
                    state_next    = S_RESP;
                end
                else if (scan_ext < fill_ext)
                begin
                    mem_raddr     = scan_reg[AW-1:0];
                    pend_idx_next = scan_reg[AW-1:0];
                    pend_vld_next = 1'b1;
                    scan_next     = scan_reg + CW'(1);
                end
                else if (pend_vld_reg)
                begin
                    pend_vld_next = 1'b0;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            // Shift up from the top: read entry k, write it to k+1 next cycle.
            S_INS:
            begin
                if (pend_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(pend_ext + ONE_EXT);
                    mem_wdata = mem_rdata;
                end
                if (scan_ext >= pos_ext)
                begin
                    mem_raddr     = AW'(scan_ext - ONE_EXT);
                    pend_idx_next = AW'(scan_ext - ONE_EXT);
                    pend_vld_next = 1'b1;
                    scan_next     = scan_reg - CW'(1);
                end
                else if (pend_vld_reg)
                begin
                    pend_vld_next = 1'b0;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_m1_ext[AW-1:0];
                    mem_wdata  = val_reg;
                    fill_next  = fill_reg + CW'(1);
                    state_next = S_RESP;
                end
            end

            // Shift down from the hole: read entry k, write it to k-1 next cycle.
            S_DEL:
            begin
                if (pend_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(pend_ext - ONE_EXT);
                    mem_wdata = mem_rdata;
                end
                if (scan_ext < fill_ext)
                begin
                    mem_raddr     = scan_reg[AW-1:0];
                    pend_idx_next = scan_reg[AW-1:0];
                    pend_vld_next = 1'b1;
                    scan_next     = scan_reg + CW'(1);
                end
                else if (pend_vld_reg)
                begin
                    pend_vld_next = 1'b0;
                end
                else
                begin
                    fill_next  = fill_reg - CW'(1);
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result as seen by the output register; count reports the low byte.
    assign res.status    = status_reg;
    assign res.data      = data_reg;
    assign res.found_at  = found_reg;
    assign res.count     = fill_ext[7:0];
    assign res.empty_res = (fill_reg == '0);

    `OLST_ASSERT_ALWAYS(a_fill_bound, fill_ext <= CAP_EXT, "fill count above capacity")
    `OLST_ASSERT_IMPLY(a_we_state, mem_we, state_reg == S_INS || state_reg == S_DEL,
        "memory written outside a shift")
    `OLST_ASSERT_IMPLY(a_full_status, res_valid && status_reg == ST_FULL,
        fill_ext == CAP_EXT, "full status reported below capacity")

endmodule

// ----- rtl/olst_outreg.sv -----
// Output register of the ordered list store: holds one result item for the consumer.
// Uses olst_pkg for the result type.
module olst_outreg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_valid,
    output logic                  res_ready,
    input  olst_pkg::olst_result_t res,
    output logic                  out_valid,
    input  logic                  out_ready,
    output olst_pkg::olst_result_t out_res
);
    import olst_pkg::*;

    logic         vld_reg, vld_next;
    olst_result_t res_reg;

    // The register takes a new item when empty or being drained.
    assign res_ready = !vld_reg || out_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (res_ready)
        begin
            vld_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = vld_reg;
    assign out_res   = res_reg;

endmodule

// ----- rtl/ordered_list_store_top.sv -----
// Top level of the ordered list store: sequencer, element memory and output register.
// Depends on olst_pkg, olst_mem, olst_seq and olst_outreg.

// An ordered list of up to CAPACITY bytes with 1-based positions, taking one request at a
// time and giving one result item per request. A read addresses the element memory, takes
// the registered read data and then offers the result; clear and rejected requests go
// straight to the result. Find, insert and delete walk the list through the element memory,
// which gives one read and one write per cycle, so a shift or a search moves one element a
// cycle. The result then passes to the output register.
// A new item is accepted as soon as the previous result sits in the output register.
module ordered_list_store_top #(
    parameter int CAPACITY = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] mode,
    input  logic [7:0] position,
    input  logic [7:0] value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] data,
    output logic [7:0] found_at,
    output logic [7:0] count,
    output logic       empty_res
);
    import olst_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic          res_valid, res_ready;
    olst_result_t  res, out_res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    olst_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .position  (position),
        .value     (value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    olst_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    olst_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    // Result fields onto their own ports.
    assign status    = out_res.status;
    assign data      = out_res.data;
    assign found_at  = out_res.found_at;
    assign count     = out_res.count;
    assign empty_res = out_res.empty_res;

endmodule
